// ----- rtl/core/sipq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sipq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int DATA_W           = 32;

    localparam logic       MODE_INSERT   = 1'b0;
    localparam logic       MODE_REMOVE   = 1'b1;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    // Command broadcast to every cell in the chain for one transaction.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/sipq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sipq_cell (
    input  wire logic                              clk,
    input  wire sipq_pkg::cell_cmd_t               cmd,
    input  wire logic                              occupied,
    input  wire logic                              prev_take,
    input  wire logic signed [sipq_pkg::DATA_W-1:0] prev_entry,
    input  wire logic signed [sipq_pkg::DATA_W-1:0] next_entry,
    output logic signed [sipq_pkg::DATA_W-1:0]      entry,
    output logic                                   take
);

    logic signed [sipq_pkg::DATA_W-1:0] entry_reg;
    logic signed [sipq_pkg::DATA_W-1:0] entry_next;

    // A cell takes part in an insert when it is empty or holds a value not below
    // the new one; since the chain is sorted, these cells form a suffix.
    assign take  = !(occupied && (entry_reg < cmd.value));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && take)
        begin
            if (prev_take)
                entry_next = prev_entry;
            else
                entry_next = cmd.value;
        end
        else if (cmd.rem)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_insert_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                           Direction  Transfer
// command   start, mode, value                in         start && !busy
// result    done, status, removed_value       out        done, one cycle
//
// All cells compare and shift in parallel at the accepting edge, and the result
// appears on the next cycle for one cycle.
// busy is always low, so a command may be issued on every cycle.
// Reset clears the entry count and the result strobe; cell contents are not reset.
// The receiver cannot stall, so no result is ever held back.

module sorted_insert_priority_queue #(
    parameter int CAPACITY = sipq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               mode,
    input  wire logic signed [sipq_pkg::DATA_W-1:0] value,
    output logic                                    done,
    output logic [1:0]                              status,
    output logic signed [sipq_pkg::DATA_W-1:0]      removed_value
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic signed [sipq_pkg::DATA_W-1:0] removed_reg;
    logic signed [sipq_pkg::DATA_W-1:0] removed_next;

    logic accept;
    logic is_full;
    logic is_empty;
    sipq_pkg::cell_cmd_t cmd;

    logic [CAPACITY-1:0] occupied;
    logic [CAPACITY-1:0] take;
    logic signed [sipq_pkg::DATA_W-1:0] entry [CAPACITY];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign cmd.ins   = accept && (mode == sipq_pkg::MODE_INSERT) && !is_full;
    assign cmd.rem   = accept && (mode == sipq_pkg::MODE_REMOVE) && !is_empty;
    assign cmd.value = value;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                               prev_take_w;
            logic signed [sipq_pkg::DATA_W-1:0] prev_entry_w;
            logic signed [sipq_pkg::DATA_W-1:0] next_entry_w;

            assign occupied[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign prev_take_w  = 1'b0;
                assign prev_entry_w = value;
            end
            else
            begin : g_body
                assign prev_take_w  = take[i-1];
                assign prev_entry_w = entry[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign next_entry_w = entry[i];
            end
            else
            begin : g_link
                assign next_entry_w = entry[i+1];
            end

            sipq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (occupied[i]),
                .prev_take  (prev_take_w),
                .prev_entry (prev_entry_w),
                .next_entry (next_entry_w),
                .entry      (entry[i]),
                .take       (take[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        status_next  = sipq_pkg::STATUS_DONE;
        removed_next = '0;
        case (mode)
            sipq_pkg::MODE_INSERT:
            begin
                if (is_full)
                    status_next = sipq_pkg::STATUS_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            sipq_pkg::MODE_REMOVE:
            begin
                if (is_empty)
                    status_next = sipq_pkg::STATUS_EMPTY;
                else
                begin
                    count_next   = count_reg - CNT_W'(1);
                    removed_next = entry[0];
                end
            end
            default:
            begin
                status_next = sipq_pkg::STATUS_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;

endmodule

`default_nettype wire

// ----- verif/sorted_insert_priority_queue_checker.sv -----
`timescale 1ns / 1ps

module sorted_insert_priority_queue_checker #(
    parameter int CAPACITY = sipq_pkg::DEFAULT_CAPACITY
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               mode,
    input  logic signed [sipq_pkg::DATA_W-1:0] value,
    input  logic                               done,
    input  logic [1:0]                         status,
    input  logic signed [sipq_pkg::DATA_W-1:0] removed_value,
    output int                                 errors,
    output int                                 outstanding
);
    import sipq_pkg::*;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] removed_value;
    } pq_outcome_t;

    // Our own copy of the queue, kept in ascending order in 0 .. held_count-1.
    logic signed [DATA_W-1:0] held_values [CAPACITY];
    int                       held_count;
    pq_outcome_t              pending_outcomes [$];
    int                       mismatch_total;

    initial
    begin
        held_count     = 0;
        mismatch_total = 0;
        errors         = 0;
        outstanding    = 0;
    end

    task automatic apply_queue_op(input logic op_mode, input logic signed [DATA_W-1:0] op_value,
                                  output pq_outcome_t outcome);
        int pos;
        int i;
        outcome.status        = STATUS_DONE;
        outcome.removed_value = '0;
        if (op_mode == MODE_INSERT)
        begin
            if (held_count >= CAPACITY)
            begin
                outcome.status = STATUS_FULL;
            end
            else
            begin
                // A new value lands ahead of any equal values already held.
                pos = 0;
                while (pos < held_count && held_values[pos] < op_value)
                    pos++;
                for (i = held_count; i > pos; i--)
                    held_values[i] = held_values[i-1];
                held_values[pos] = op_value;
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                outcome.status = STATUS_EMPTY;
            end
            else
            begin
                outcome.removed_value = held_values[0];
                for (i = 0; i + 1 < held_count; i++)
                    held_values[i] = held_values[i+1];
                held_count--;
            end
        end
    endtask

    always @(posedge clk)
    begin
        pq_outcome_t seen;
        pq_outcome_t want;
        pq_outcome_t fresh;
        if (rst_n)
        begin
            // A result comes out the cycle after its transaction, so it is
            // checked before this edge's transaction is predicted.
            if (done)
            begin
                seen.status        = status;
                seen.removed_value = removed_value;
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got status %0d value %0d",
                             $time, seen.status, seen.removed_value);
                    mismatch_total++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (seen.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, seen.status);
                        mismatch_total++;
                    end
                    if (seen.removed_value !== want.removed_value)
                    begin
                        $display("%0t: removed_value mismatch, expected %0d, got %0d",
                                 $time, want.removed_value, seen.removed_value);
                        mismatch_total++;
                    end
                end
            end
            if (start && !busy)
            begin
                apply_queue_op(mode, value, fresh);
                pending_outcomes.push_back(fresh);
            end
        end
        errors      <= mismatch_total;
        outstanding <= pending_outcomes.size();
    end

endmodule

// ----- verif/sorted_insert_priority_queue_tb.sv -----
`timescale 1ns / 1ps

module sorted_insert_priority_queue_tb;
    import sipq_pkg::*;

    localparam int                       CAPACITY  = DEFAULT_CAPACITY;
    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    logic                     clk   = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     mode  = MODE_INSERT;
    logic signed [DATA_W-1:0] value = '0;
    logic                     busy;
    logic                     done;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] removed_value;
    int                       errors;
    int                       outstanding;
    bit                       idle_allowed = 1'b1;

    sorted_insert_priority_queue #(
        .CAPACITY      (CAPACITY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .value         (value),
        .done          (done),
        .status        (status),
        .removed_value (removed_value)
    );

    sorted_insert_priority_queue_checker #(
        .CAPACITY      (CAPACITY)
    ) pq_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .value         (value),
        .done          (done),
        .status        (status),
        .removed_value (removed_value),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Extremes, a narrow band around zero so that equal values show up often, and otherwise random values.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2, 3, 4: return $urandom_range(0, 8) - 4;
            default: return $urandom;
        endcase
    endfunction

    // While idle_allowed is set, each cycle before the transaction is idle with the same
    // chance; then start is held high until the transaction is taken.
    task automatic issue_op(input logic op_mode, input logic signed [DATA_W-1:0] op_value);
        if (idle_allowed)
        begin
            while ($urandom_range(0, 99) < 34)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        mode  <= op_mode;
        value <= op_value;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        int n;
        int phase_left;
        int insert_pct;
        phase_left = 0;
        insert_pct = 50;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_op(MODE_REMOVE, VALUE_MAX);
        issue_op(MODE_INSERT, VALUE_MAX);
        issue_op(MODE_INSERT, VALUE_MIN);
        issue_op(MODE_INSERT, 32'sd0);
        issue_op(MODE_INSERT, -32'sd1);
        issue_op(MODE_INSERT, 32'sd0);
        issue_op(MODE_INSERT, 32'sd1);
        issue_op(MODE_INSERT, VALUE_MAX);
        issue_op(MODE_INSERT, VALUE_MIN);
        repeat (CAPACITY - 8) issue_op(MODE_INSERT, 32'sd5);
        issue_op(MODE_INSERT, -32'sd7);
        repeat (4) issue_op(MODE_REMOVE, $urandom);

        // Phases lean toward filling, draining or mixing so the queue keeps
        // reaching both its full and its empty state.
        for (n = 0; n < 630; n++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(10, 40);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            phase_left--;
            idle_allowed = !(n >= 120 && n < 280);
            if (n == 400)
                wait_for_results();
            issue_op(($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE,
                     pick_value());
        end

        wait_for_results();
        repeat (4) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("** sorted_insert_priority_queue: PASSED **");
        else
            $display("** sorted_insert_priority_queue: FAILED **");
        $finish;
    end

    initial
    begin
        #200000;
        $display("** sorted_insert_priority_queue: FAILED **");
        $finish;
    end

endmodule

// ----- sorted_insert_priority_queue.f -----
rtl/core/sipq_pkg.sv
rtl/core/sipq_cell.sv
rtl/core/sorted_insert_priority_queue.sv
verif/sorted_insert_priority_queue_checker.sv
verif/sorted_insert_priority_queue_tb.sv
